### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/lrcf_pkg.sv
// Types, codes and the CRC byte update for the log record framer.
package lrcf_pkg;

    localparam int ADDR_W = 13;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_SET_SLOT = 1'b1;

    localparam logic [1:0] STEP_CHAR = 2'd0;
    localparam logic [1:0] STEP_TERM = 2'd1;
    localparam logic [1:0] STEP_CRC_HI = 2'd2;
    localparam logic [1:0] STEP_CRC_LO = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic       command;
        logic [7:0] value;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              record_end;
    } rec_t;

    typedef struct packed {
        logic              has_char;
        logic [7:0]        char_byte;
        logic [ADDR_W-1:0] char_addr;
        logic              has_tail;
        logic [15:0]       crc;
        logic [ADDR_W-1:0] tail_addr;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ (x >> 4);
        return (crc << 8) ^ ({8'h00, x} << 12) ^ ({8'h00, x} << 5) ^ {8'h00, x};
    endfunction

endpackage

### rtl/lrcf_front.sv
// Front end: accepts items, keeps CRC, count and slot state, forms record jobs.
module lrcf_front #(
    parameter int RECORD_BYTES = 64,
    parameter int SLOT_COUNT = 128,
    parameter int MAX_TEXT = 59
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  lrcf_pkg::item_t item,
    output logic           push,
    output lrcf_pkg::job_t job
);
    import lrcf_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(MAX_TEXT + 1);

    logic [15:0]       crc_reg, crc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              keep;
    logic [15:0]       crc_kept;
    logic [CNT_W-1:0]  count_kept;
    logic [31:0]       base;

    always_comb
    begin
        keep = (count_reg < CNT_W'(MAX_TEXT));
        crc_kept = keep ? crc_byte(crc_reg, item.value) : crc_reg;
        count_kept = keep ? count_reg + CNT_W'(1) : count_reg;
        base = 32'(slot_reg) * 32'(RECORD_BYTES);

        job.has_char = keep;
        job.char_byte = item.value;
        job.char_addr = ADDR_W'(base + 32'(count_reg));
        job.has_tail = item.last_char;
        job.crc = crc_byte(crc_kept, 8'h00);
        job.tail_addr = ADDR_W'(base + 32'(count_kept));

        push = take && (item.command == CMD_CHAR) && (keep || item.last_char);

        crc_next = crc_reg;
        count_next = count_reg;
        slot_next = slot_reg;
        if (take)
        begin
            unique case (item.command)
                CMD_SET_SLOT:
                begin
                    slot_next = (32'(item.value) < 32'(SLOT_COUNT)) ? SLOT_W'(item.value)
                                                                    : '0;
                end
                CMD_CHAR:
                begin
                    if (item.last_char)
                    begin
                        crc_next = CRC_INIT;
                        count_next = '0;
                        slot_next = (slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                          : slot_reg + SLOT_W'(1);
                    end
                    else
                    begin
                        crc_next = crc_kept;
                        count_next = count_kept;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            count_reg <= '0;
            slot_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            count_reg <= count_next;
            slot_reg <= slot_next;
        end
    end

endmodule

### rtl/lrcf_queue.sv
// Short job queue between the front end and the byte emitter.
module lrcf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lrcf_pkg::job_t job_in,
    input  logic           pop,
    output lrcf_pkg::job_t job_out,
    output logic           not_empty,
    output logic           full
);
    import lrcf_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        job_out = entry_reg[rd_ptr_reg];
        not_empty = (count_reg != '0);
        full = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/lrcf_back.sv
// Back end: expands each job into record bytes behind an output register.
module lrcf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           has_job,
    input  lrcf_pkg::job_t job,
    output logic           pop,
    output logic           rec_valid,
    input  logic           rec_stall,
    output lrcf_pkg::rec_t rec_data
);
    import lrcf_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    rec_t       data_reg, data_next;
    logic [1:0] step;
    logic       last_step;
    logic       load;

    always_comb
    begin
        step = ((pos_reg == STEP_CHAR) && !job.has_char) ? STEP_TERM : pos_reg;
        last_step = ((step == STEP_CHAR) && !job.has_tail) || (step == STEP_CRC_LO);
        load = has_job && (!valid_reg || !rec_stall);
        pop = load && last_step;

        unique case (step)
            STEP_CHAR:
            begin
                data_next.out_byte = job.char_byte;
                data_next.byte_address = job.char_addr;
                data_next.record_end = 1'b0;
            end
            STEP_TERM:
            begin
                data_next.out_byte = 8'h00;
                data_next.byte_address = job.tail_addr;
                data_next.record_end = 1'b0;
            end
            STEP_CRC_HI:
            begin
                data_next.out_byte = job.crc[15:8];
                data_next.byte_address = job.tail_addr + ADDR_W'(1);
                data_next.record_end = 1'b0;
            end
            STEP_CRC_LO:
            begin
                data_next.out_byte = job.crc[7:0];
                data_next.byte_address = job.tail_addr + ADDR_W'(2);
                data_next.record_end = 1'b1;
            end
        endcase

        if (load)
        begin
            valid_next = 1'b1;
            pos_next = last_step ? STEP_CHAR : step + 2'd1;
        end
        else
        begin
            valid_next = valid_reg && rec_stall;
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg <= STEP_CHAR;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg <= pos_next;
        end
    end

    assign rec_valid = valid_reg;
    assign rec_data = data_reg;

endmodule

### rtl/log_record_crc_framer.sv
// Top level of the log record framer with CRC-16/CCITT-FALSE.
//
//   channel | signals                          | direction
//   item    | item_valid, item_stall, item_data | into the block
//   rec     | rec_valid, rec_stall, rec_data    | out of the block
//
// A four-entry job queue sits between front and back. The output register moves one
// record byte per cycle while a job is queued and rec_stall is low: a closing item gives
// 3 or 4 bytes, a plain character 1, a set-slot command or dropped character 0.
// item_stall rises only while the job queue is full.
// Reset clears CRC to 0xFFFF, count and slot to zero, and empties the queue.
module log_record_crc_framer #(
    parameter int RECORD_BYTES = 64,
    parameter int SLOT_COUNT = 128,
    parameter int MAX_TEXT = 59
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  lrcf_pkg::item_t item_data,
    output logic            rec_valid,
    input  logic            rec_stall,
    output lrcf_pkg::rec_t  rec_data
);
    import lrcf_pkg::*;

    logic take;
    logic push;
    logic pop;
    logic not_empty;
    logic full;
    job_t job_new;
    job_t job_head;

    assign item_stall = full;
    assign take = item_valid && !full;

    lrcf_front #(
        .RECORD_BYTES(RECORD_BYTES),
        .SLOT_COUNT(SLOT_COUNT),
        .MAX_TEXT(MAX_TEXT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .take(take),
        .item(item_data),
        .push(push),
        .job(job_new)
    );

    lrcf_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .job_in(job_new),
        .pop(pop),
        .job_out(job_head),
        .not_empty(not_empty),
        .full(full)
    );

    lrcf_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .has_job(not_empty),
        .job(job_head),
        .pop(pop),
        .rec_valid(rec_valid),
        .rec_stall(rec_stall),
        .rec_data(rec_data)
    );

endmodule

### rtl/lrcf_checker.sv
// Port-level checks for the log record framer and their bind.
`include "assert_macros.svh"

module lrcf_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            item_stall,
    input logic            rec_valid,
    input logic            rec_stall,
    input lrcf_pkg::rec_t  rec_data
);
    import lrcf_pkg::*;

    `ASSERT_CLK(a_rec_hold, rec_valid && rec_stall |=> rec_valid && $stable(rec_data), "stalled record byte changed")
    `ASSERT_CLK(a_stall_needs_backlog, item_stall |-> rec_valid, "input stalled with no record byte pending")
    `ASSERT_CLK_ALWAYS(a_reset_quiet, !rst_n |-> !rec_valid && !item_stall, "outputs active during reset")

endmodule

bind log_record_crc_framer lrcf_checker u_lrcf_checker (
    .clk(clk),
    .rst_n(rst_n),
    .item_stall(item_stall),
    .rec_valid(rec_valid),
    .rec_stall(rec_stall),
    .rec_data(rec_data)
);
